[src/lpkv_pkg.sv]
package lpkv_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   // home slot: residue of each key byte from a constant table, then summed
   localparam int KEY_BYTES = KEY_W / 8;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

[src/lpkv_ram.sv]
module lpkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/linear_probe_kv_store_top.sv]
// Channel   Ports                                          Handshake
// request   req_mode, req_key, req_value                   transfer when start && !busy
// response  rsp_read_value, rsp_found, rsp_status          one-cycle strobe rsp_valid
//
// After its transfer an item sums the per-byte key residues into the home slot in ST_MOD,
// reads that slot through the registered slot RAM output, then checks one slot a cycle
// until a hit, an empty slot or a full table decides it.
// busy falls with the response strobe, so the next transfer can land on the edge that takes
// the response. A zero key is taken and gives no response.
// After reset the slot RAM is cleared, one slot a cycle, with busy high.
// The receiver cannot stall.
module linear_probe_kv_store_top #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_mode,
   input  logic [lpkv_pkg::KEY_W-1:0]   req_key,
   input  logic [lpkv_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   output logic [lpkv_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                         rsp_found,
   output logic                         rsp_status
);

   localparam int AW   = $clog2(TABLE_SLOTS);
   localparam int CNTW = $clog2(TABLE_SLOTS + 1);
   localparam int KB_W = $clog2(lpkv_pkg::KEY_BYTES);

   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SLOTS - 1);
   localparam logic [AW+1:0] SLOTS_X1  = (AW + 2)'(TABLE_SLOTS);
   localparam logic [AW+1:0] SLOTS_X2  = (AW + 2)'(2 * TABLE_SLOTS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;

   logic [2:0] state_ff, state_in;

   logic                         mode_ff;
   logic [lpkv_pkg::KEY_W-1:0]   key_ff;
   logic [lpkv_pkg::VALUE_W-1:0] value_ff;
   logic [lpkv_pkg::KEY_BYTES-1:0][AW-1:0] part_ff, part_in;
   logic [AW+1:0]                fold_sum, fold_half, fold_home;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] issue_addr_ff, issue_addr_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] probe_cnt_ff, probe_cnt_in;
   logic [CNTW-1:0] entry_count_ff, entry_count_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lpkv_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic                         rsp_status_ff, rsp_status_in;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   lpkv_pkg::slot_type        ram_wdata;
   logic                      ram_re;
   logic [lpkv_pkg::SLOT_W-1:0] ram_rdata;
   lpkv_pkg::slot_type        slot;

   logic hit, empty, full;

   lpkv_ram #(
      .WIDTH(lpkv_pkg::SLOT_W),
      .DEPTH(TABLE_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(issue_addr_ff),
      .rd_data(ram_rdata)
   );

   assign slot  = lpkv_pkg::slot_type'(ram_rdata);
   assign hit   = chk_vld_ff && slot.valid && (slot.key == key_ff);
   assign empty = chk_vld_ff && !slot.valid;
   assign full  = chk_vld_ff && slot.valid && (slot.key != key_ff) &&
                  (probe_cnt_ff == LAST_ADDR);
   assign ram_re = (state_ff == ST_PROBE);

   // residue of each key byte times its weight, a constant table per byte position
   always_comb begin
      part_in = '0;
      for (int k = 0; k < lpkv_pkg::KEY_BYTES; k++) begin
         for (int b = 0; b < 256; b++) begin
            if (req_key[8*k +: 8] == 8'(b)) begin
               part_in[k[KB_W-1:0]] =
                  AW'((b * ((1 << (8 * k)) % TABLE_SLOTS)) % TABLE_SLOTS);
            end
         end
      end
   end

   // four residues sum below 4 * TABLE_SLOTS: two compare-subtracts bring it home
   always_comb begin
      fold_sum = '0;
      for (int k = 0; k < lpkv_pkg::KEY_BYTES; k++) begin
         fold_sum = fold_sum + {2'b00, part_ff[k[KB_W-1:0]]};
      end
      fold_half = (fold_sum >= SLOTS_X2) ? fold_sum - SLOTS_X2 : fold_sum;
      fold_home = (fold_half >= SLOTS_X1) ? fold_half - SLOTS_X1 : fold_half;
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      issue_addr_in  = issue_addr_ff;
      chk_addr_in    = chk_addr_ff;
      chk_vld_in     = 1'b0;
      probe_cnt_in   = probe_cnt_ff;
      entry_count_in = entry_count_ff;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = rsp_value_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_status_in  = rsp_status_ff;
      ram_we         = 1'b0;
      ram_waddr      = chk_addr_ff;
      ram_wdata      = '{valid: 1'b1, key: key_ff, value: value_ff};

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // drop zero keys: no request, no response
            if (start && (req_key != '0)) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            state_in      = ST_PROBE;
            issue_addr_in = fold_home[AW-1:0];
            probe_cnt_in  = '0;
         end
         ST_PROBE: begin
            // issue the next slot ahead; a read past the decision is harmless
            chk_vld_in    = 1'b1;
            chk_addr_in   = issue_addr_ff;
            issue_addr_in = (issue_addr_ff == LAST_ADDR) ? '0 : issue_addr_ff + AW'(1);
            if (hit || empty || full) begin
               state_in      = ST_IDLE;
               chk_vld_in    = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_found_in  = hit;
               rsp_status_in = (mode_ff == lpkv_pkg::MODE_PUT && full) ?
                               lpkv_pkg::STATUS_FULL : lpkv_pkg::STATUS_OK;
               rsp_value_in  = (mode_ff == lpkv_pkg::MODE_GET && hit) ? slot.value : '0;
               if (mode_ff == lpkv_pkg::MODE_PUT && (hit || empty)) begin
                  ram_we = 1'b1;
               end
               if (mode_ff == lpkv_pkg::MODE_PUT && empty) begin
                  entry_count_in = entry_count_ff + CNTW'(1);
               end
            end else if (chk_vld_ff) begin
               probe_cnt_in = probe_cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         chk_vld_ff     <= 1'b0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         probe_cnt_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         chk_vld_ff     <= chk_vld_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         probe_cnt_ff   <= probe_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
         part_ff  <= part_in;
      end
      issue_addr_ff <= issue_addr_in;
      chk_addr_ff   <= chk_addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lpkv_pkg::STATUS_FULL) |->
         (!rsp_found && rsp_read_value == '0))
      else $error("full response carries data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNTW'(TABLE_SLOTS))
      else $error("entry count above slot count");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || (state_ff == ST_PROBE && rsp_valid_in)))
      else $error("slot write outside clear pass or decision");

   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_value != '0) |-> rsp_found)
      else $error("value returned without a hit");

endmodule
